/* hdl/rcmsc_pkg.sv */
// Shared types, constants and codes for the RC motor speed controller.
// Used by every module under hdl; depends on nothing else.

package rcmsc_pkg;

    // Request fields as they arrive on the input channel.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] pulse_width;
        logic        battery_low;
    } in_item_t;

    // Fields of one result.
    typedef struct packed {
        logic [7:0] motor_duty;
        logic       led_on;
        logic [2:0] mode;
        logic [5:0] signal_score;
    } out_item_t;

    // Configuration registers.
    typedef struct packed {
        logic [15:0] valid_min_width;
        logic [15:0] valid_max_width;
        logic [15:0] clamp_low_width;
        logic [15:0] clamp_high_width;
        logic [5:0]  arm_threshold;
    } cfg_t;

    typedef enum logic [2:0] {
        CFG_VALID_MIN  = 3'd0,
        CFG_VALID_MAX  = 3'd1,
        CFG_CLAMP_LOW  = 3'd2,
        CFG_CLAMP_HIGH = 3'd3,
        CFG_ARM_THRESH = 3'd4
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] VALID_MIN_RST  = 16'd4000;
    localparam logic [15:0] VALID_MAX_RST  = 16'd12000;
    localparam logic [15:0] CLAMP_LOW_RST  = 16'd4600;
    localparam logic [15:0] CLAMP_HIGH_RST = 16'd7660;
    localparam logic [5:0]  ARM_THRESH_RST = 6'd30;

    // Action codes of the input field.
    localparam logic [1:0] ACT_PULSE = 2'd0;
    localparam logic [1:0] ACT_SLOW  = 2'd1;
    localparam logic [1:0] ACT_PWM   = 2'd2;

    // What the front end makes of a request.
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_PULSE_GOOD,
        KIND_PULSE_BAD,
        KIND_SLOW,
        KIND_PWM
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] command;
        logic       battery_low;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        MODE_RESET       = 3'd0,
        MODE_WAIT_SIGNAL = 3'd1,
        MODE_WAIT_STICK  = 3'd2,
        MODE_RUN         = 3'd3,
        MODE_POWER_DOWN  = 3'd4,
        MODE_CHECK_POWER = 3'd5
    } mode_t;

    // Width scaling: x / 12 is (x >> 2) / 3, and y / 3 = (y * 43691) >> 17
    // exactly for any y below 2**17.
    localparam logic [16:0] RECIP_THIRD = 17'd43691;
    localparam int          RECIP_SHIFT = 17;

    localparam logic [5:0]  SCORE_CEIL      = 6'd40;
    localparam logic [5:0]  PG_CEIL         = 6'd30;
    localparam logic [5:0]  PG_START        = 6'd50;
    localparam logic [5:0]  PG_DERATE       = 6'd2;
    localparam logic [5:0]  PG_RECOVER      = 6'd25;
    localparam logic [7:0]  POWER_FULL      = 8'd255;
    localparam logic [7:0]  POWER_FLOOR     = 8'd200;
    localparam logic [7:0]  POWER_STEP      = 8'd5;
    localparam logic [7:0]  CMD_MAX         = 8'd255;
    localparam logic [7:0]  STICK_LOW       = 8'd10;
    localparam logic [7:0]  STICK_RECOVER   = 8'd5;
    localparam logic [7:0]  ARM_DUTY        = 8'd10;
    localparam logic [3:0]  ARM_COUNT_LIMIT = 4'd10;
    localparam logic [2:0]  TICK_RELOAD     = 3'd4;
    localparam logic [11:0] BLINK_SLOW      = 12'd2000;
    localparam logic [11:0] BLINK_STICK     = 12'd200;
    localparam logic [11:0] BLINK_FAST      = 12'd50;
    localparam logic [11:0] BLINK_DERATE    = 12'd400;
    localparam logic [11:0] BLINK_FAULT     = 12'd4000;

    localparam int QUEUE_DEPTH_DEF = 2;

endpackage

/* hdl/rcmsc_front.sv */
// Front end: classifies each request and scales a pulse width to a command.
// Depends on rcmsc_pkg.

module rcmsc_front (
    input  rcmsc_pkg::in_item_t item,
    input  rcmsc_pkg::cfg_t     cfg,
    output rcmsc_pkg::entry_t   entry
);

    logic        good;
    logic [15:0] w_low;
    logic [15:0] w_clamped;
    logic [15:0] diff;
    logic [30:0] prod;
    logic [13:0] quot;

    assign good = (item.pulse_width > cfg.valid_min_width)
               && (item.pulse_width < cfg.valid_max_width);

    assign w_low     = (item.pulse_width < cfg.clamp_low_width) ? cfg.clamp_low_width
                                                                : item.pulse_width;
    assign w_clamped = (w_low > cfg.clamp_high_width) ? cfg.clamp_high_width : w_low;
    // Crossed clamps can leave the width below the lower clamp; that is command zero.
    assign diff      = (w_clamped > cfg.clamp_low_width) ? (w_clamped - cfg.clamp_low_width)
                                                         : 16'd0;
    assign prod      = {17'd0, diff[15:2]} * {14'd0, rcmsc_pkg::RECIP_THIRD};
    assign quot      = prod[rcmsc_pkg::RECIP_SHIFT +: 14];

    always_comb
    begin
        entry.command     = (quot > 14'(rcmsc_pkg::CMD_MAX)) ? rcmsc_pkg::CMD_MAX : quot[7:0];
        entry.battery_low = item.battery_low;
        unique case (item.action)
            rcmsc_pkg::ACT_PULSE:
            begin
                entry.kind = good ? rcmsc_pkg::KIND_PULSE_GOOD : rcmsc_pkg::KIND_PULSE_BAD;
            end
            rcmsc_pkg::ACT_SLOW:
            begin
                entry.kind = rcmsc_pkg::KIND_SLOW;
            end
            rcmsc_pkg::ACT_PWM:
            begin
                entry.kind = rcmsc_pkg::KIND_PWM;
            end
            default:
            begin
                entry.kind = rcmsc_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

/* hdl/rcmsc_queue.sv */
// Short FIFO of classified requests between the front and back ends.
// Depends on rcmsc_pkg.

module rcmsc_queue #(
    parameter int DEPTH = rcmsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rcmsc_pkg::entry_t      push_entry,
    input  logic                   pop,
    output rcmsc_pkg::entry_t      head,
    output rcmsc_pkg::q_status_t   status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rcmsc_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

/* hdl/rcmsc_back.sv */
// Back end: holds the controller state, carries out one queued request per
// cycle unless the output stalls, and registers the result. Depends on rcmsc_pkg.

module rcmsc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rcmsc_pkg::cfg_t      cfg,
    input  rcmsc_pkg::entry_t    head,
    input  rcmsc_pkg::q_status_t q_status,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rcmsc_pkg::out_item_t out_data
);

    rcmsc_pkg::mode_t mode_reg, mode_next, mode_run;
    logic [5:0]  score_reg, score_next;
    logic [7:0]  command_reg, command_next;
    logic [5:0]  pg_reg, pg_next;
    logic [7:0]  max_power_reg, max_power_next;
    logic [3:0]  arm_count_reg, arm_count_next;
    logic [11:0] blink_reg, blink_next;
    logic [2:0]  tick_reg, tick_next;
    logic        led_reg, led_next;
    logic [7:0]  duty_reg, duty_next;
    logic        run;
    logic        out_valid_reg;
    rcmsc_pkg::out_item_t out_data_reg;

    assign pop = !q_status.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        mode_next      = mode_reg;
        score_next     = score_reg;
        command_next   = command_reg;
        pg_next        = pg_reg;
        max_power_next = max_power_reg;
        arm_count_next = arm_count_reg;
        blink_next     = blink_reg;
        tick_next      = tick_reg;
        led_next       = led_reg;
        duty_next      = duty_reg;
        run            = 1'b0;

        case (head.kind)
            rcmsc_pkg::KIND_PULSE_GOOD:
            begin
                if (score_reg < rcmsc_pkg::SCORE_CEIL)
                begin
                    score_next = score_reg + 6'd2;
                end
                command_next = head.command;
                run          = 1'b1;
            end
            rcmsc_pkg::KIND_PULSE_BAD:
            begin
                if (score_reg != 6'd0)
                begin
                    score_next = score_reg - 6'd1;
                end
            end
            rcmsc_pkg::KIND_SLOW:
            begin
                if (tick_reg != 3'd0)
                begin
                    tick_next = tick_reg - 3'd1;
                end
                else
                begin
                    tick_next = rcmsc_pkg::TICK_RELOAD;
                    if (score_reg > 6'd1)
                    begin
                        score_next = score_reg - 6'd1;
                    end
                    run = 1'b1;
                end
            end
            rcmsc_pkg::KIND_PWM:
            begin
                if (blink_reg != 12'd0)
                begin
                    blink_next = blink_reg - 12'd1;
                end
                else
                begin
                    unique case (mode_reg)
                        rcmsc_pkg::MODE_WAIT_STICK:
                        begin
                            blink_next = rcmsc_pkg::BLINK_STICK;
                            duty_next  = led_reg ? rcmsc_pkg::ARM_DUTY : 8'd0;
                        end
                        rcmsc_pkg::MODE_WAIT_SIGNAL:
                        begin
                            blink_next = rcmsc_pkg::BLINK_SLOW;
                            duty_next  = led_reg ? rcmsc_pkg::ARM_DUTY : 8'd0;
                        end
                        rcmsc_pkg::MODE_RUN:
                        begin
                            blink_next = rcmsc_pkg::BLINK_FAST;
                        end
                        rcmsc_pkg::MODE_POWER_DOWN:
                        begin
                            blink_next = led_reg ? rcmsc_pkg::BLINK_FAST
                                                 : rcmsc_pkg::BLINK_DERATE;
                        end
                        rcmsc_pkg::MODE_CHECK_POWER:
                        begin
                            blink_next = led_reg ? rcmsc_pkg::BLINK_FAST
                                                 : rcmsc_pkg::BLINK_FAULT;
                        end
                        default:
                        begin
                            blink_next = rcmsc_pkg::BLINK_SLOW;
                        end
                    endcase
                    if (head.battery_low)
                    begin
                        if (pg_reg != 6'd0)
                        begin
                            pg_next = pg_reg - 6'd1;
                        end
                    end
                    else if (pg_reg < rcmsc_pkg::PG_CEIL)
                    begin
                        pg_next = pg_reg + 6'd1;
                    end
                    led_next = !led_reg;
                end
            end
            default:
            begin
            end
        endcase

        // The arming and battery machine sees the values the event has just made.
        mode_run = (score_next == 6'd0) ? rcmsc_pkg::MODE_RESET : mode_reg;
        if (run)
        begin
            mode_next = mode_run;
            unique case (mode_run)
                rcmsc_pkg::MODE_RESET:
                begin
                    pg_next        = rcmsc_pkg::PG_START;
                    max_power_next = rcmsc_pkg::POWER_FULL;
                    arm_count_next = 4'd0;
                    score_next     = 6'd1;
                    mode_next      = (cfg.arm_threshold == 6'd0) ? rcmsc_pkg::MODE_WAIT_STICK
                                                                 : rcmsc_pkg::MODE_WAIT_SIGNAL;
                end
                rcmsc_pkg::MODE_WAIT_SIGNAL:
                begin
                    if (score_next > cfg.arm_threshold)
                    begin
                        mode_next = rcmsc_pkg::MODE_WAIT_STICK;
                    end
                end
                rcmsc_pkg::MODE_WAIT_STICK:
                begin
                    if (arm_count_reg != 4'd0)
                    begin
                        arm_count_next = arm_count_reg - 4'd1;
                    end
                    if (command_next < rcmsc_pkg::STICK_LOW)
                    begin
                        if (arm_count_next < rcmsc_pkg::ARM_COUNT_LIMIT)
                        begin
                            arm_count_next = arm_count_next + 4'd2;
                        end
                        else
                        begin
                            mode_next = rcmsc_pkg::MODE_RUN;
                        end
                    end
                end
                rcmsc_pkg::MODE_RUN:
                begin
                    if (pg_next == 6'd0)
                    begin
                        pg_next        = rcmsc_pkg::PG_CEIL;
                        max_power_next = rcmsc_pkg::POWER_FULL;
                        mode_next      = rcmsc_pkg::MODE_POWER_DOWN;
                    end
                    duty_next = command_next;
                end
                rcmsc_pkg::MODE_POWER_DOWN:
                begin
                    if (pg_next == 6'd0)
                    begin
                        max_power_next = max_power_reg - rcmsc_pkg::POWER_STEP;
                        pg_next        = rcmsc_pkg::PG_DERATE;
                        if (max_power_next < rcmsc_pkg::POWER_FLOOR)
                        begin
                            max_power_next = 8'd0;
                            mode_next      = rcmsc_pkg::MODE_CHECK_POWER;
                        end
                    end
                    duty_next = (command_next > max_power_next) ? max_power_next
                                                                : command_next;
                end
                rcmsc_pkg::MODE_CHECK_POWER:
                begin
                    if ((pg_next == rcmsc_pkg::PG_RECOVER)
                        && (command_next < rcmsc_pkg::STICK_RECOVER))
                    begin
                        mode_next = rcmsc_pkg::MODE_RUN;
                    end
                    duty_next = 8'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= rcmsc_pkg::MODE_RESET;
            score_reg     <= '0;
            command_reg   <= '0;
            pg_reg        <= '0;
            max_power_reg <= '0;
            arm_count_reg <= '0;
            blink_reg     <= '0;
            tick_reg      <= '0;
            led_reg       <= 1'b0;
            duty_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg      <= mode_next;
                score_reg     <= score_next;
                command_reg   <= command_next;
                pg_reg        <= pg_next;
                max_power_reg <= max_power_next;
                arm_count_reg <= arm_count_next;
                blink_reg     <= blink_next;
                tick_reg      <= tick_next;
                led_reg       <= led_next;
                duty_reg      <= duty_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg.motor_duty   <= duty_next;
            out_data_reg.led_on       <= led_next;
            out_data_reg.mode         <= 3'(mode_next);
            out_data_reg.signal_score <= score_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/rc_motor_speed_controller.sv */
// Top level of the RC motor speed controller: configuration registers, front
// end, request queue and back end. Depends on rcmsc_pkg and the rcmsc_* modules.
//
// Usage. Each request on in_data is a pulse measurement, a slow period tick or
// a PWM period tick; it is taken at a clock edge where in_valid is high and
// in_stall is low. Every request yields exactly one result on out_data, which
// the receiver takes at an edge where out_valid is high and out_stall is low.
// A taken request is queued and its result registered when the back end pops
// it; one request per cycle is sustained while out_stall is low, set by the
// single state update in the back end. The QUEUE_DEPTH-entry queue lets the
// front keep taking requests while a result waits at a stalled output; in_stall
// rises only when the queue is full, and a stalled result holds its value.
// Registers are written on the cfg channel (cfg_ready is always high) by index:
// 0 valid min width, 1 valid max width, 2 lower clamp, 3 upper clamp, 4 arming
// threshold; other indexes are ignored. Write them only while no request is
// outstanding. Reset restores the register defaults and puts the controller in
// the resetting mode with all counters, the LED and the duty at zero.

module rc_motor_speed_controller #(
    parameter int QUEUE_DEPTH = rcmsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  rcmsc_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output rcmsc_pkg::out_item_t                 out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rcmsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rcmsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rcmsc_pkg::cfg_t      cfg_reg;
    rcmsc_pkg::entry_t    front_entry;
    rcmsc_pkg::entry_t    head;
    rcmsc_pkg::q_status_t q_status;
    logic                 push;
    logic                 pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.valid_min_width  <= rcmsc_pkg::VALID_MIN_RST;
            cfg_reg.valid_max_width  <= rcmsc_pkg::VALID_MAX_RST;
            cfg_reg.clamp_low_width  <= rcmsc_pkg::CLAMP_LOW_RST;
            cfg_reg.clamp_high_width <= rcmsc_pkg::CLAMP_HIGH_RST;
            cfg_reg.arm_threshold    <= rcmsc_pkg::ARM_THRESH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rcmsc_pkg::CFG_VALID_MIN:  cfg_reg.valid_min_width  <= cfg_data;
                rcmsc_pkg::CFG_VALID_MAX:  cfg_reg.valid_max_width  <= cfg_data;
                rcmsc_pkg::CFG_CLAMP_LOW:  cfg_reg.clamp_low_width  <= cfg_data;
                rcmsc_pkg::CFG_CLAMP_HIGH: cfg_reg.clamp_high_width <= cfg_data;
                rcmsc_pkg::CFG_ARM_THRESH: cfg_reg.arm_threshold    <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !in_stall;

    rcmsc_front u_front (
        .item  (in_data),
        .cfg   (cfg_reg),
        .entry (front_entry)
    );

    rcmsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    rcmsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // The score can overshoot its ceiling by one step of two, never more.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.signal_score <= (rcmsc_pkg::SCORE_CEIL + 6'd1)))
    else $error("signal score above its ceiling");

    // The motor is held off while the supply is being checked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.mode == 3'(rcmsc_pkg::MODE_CHECK_POWER)))
        |-> (out_data.motor_duty == 8'd0))
    else $error("motor driven during power check");

    // A fresh result can only come from a request that was waiting in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_status.empty))
    else $error("result produced with the queue empty");

endmodule
